// ===== rtl/spsfl_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and reset values for the steering pot servo
package spsfl_pkg;

    // operation selector on the input side
    typedef enum logic
    {
        OP_TURN  = 1'b0,
        OP_DRIVE = 1'b1
    } op_t;

    // turn command codes
    typedef enum logic [1:0]
    {
        TURN_STOP = 2'd0,
        TURN_INC  = 2'd1,
        TURN_DEC  = 2'd2
    } turn_cmd_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_POT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_TOL      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REENGAGE_TOL  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_GUARD    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FAULT_LOW     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FAULT_HIGH    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FAULT_RUN_LEN = 3'd6;

    // reset values
    localparam logic [7:0] RST_TARGET_POT    = 8'd127;
    localparam logic [7:0] RST_STOP_TOL      = 8'd2;
    localparam logic [7:0] RST_REENGAGE_TOL  = 8'd5;
    localparam logic [6:0] RST_EDGE_GUARD    = 7'd10;
    localparam logic [7:0] RST_FAULT_LOW     = 8'd0;
    localparam logic [7:0] RST_FAULT_HIGH    = 8'd255;
    localparam logic [7:0] RST_FAULT_RUN_LEN = 8'd3;
    localparam logic [7:0] RST_LAST_READING  = 8'd127;
    localparam logic [7:0] POT_MAX           = 8'd255;

    // stream widths
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 24;
    localparam int unsigned M_TUSER_W = 2;

    typedef struct packed
    {
        logic [7:0] target_pot;
        logic [7:0] stop_tol;
        logic [7:0] reengage_tol;
        logic [6:0] edge_guard;
        logic [7:0] fault_low;
        logic [7:0] fault_high;
        logic [7:0] fault_run_len;
    } cfg_t;

    typedef struct packed
    {
        op_t               op;
        logic [9:0]        pot_raw;
        logic signed [7:0] drive_request;
    } item_t;

    typedef struct packed
    {
        logic              turn_valid;
        turn_cmd_t         turn_cmd;
        logic              drive_valid;
        logic              drive_stop;
        logic signed [7:0] drive_effort;
        logic [7:0]        pot_value;
        logic              aligned_flag;
        logic              fault_flag;
    } result_t;

    // servo state seen from outside the core
    typedef struct packed
    {
        logic frozen;
        logic aligned;
    } status_t;

endpackage

// ===== rtl/spsfl_cfg.sv =====
`timescale 1ns / 1ps
// configuration register file for the steering pot servo
module spsfl_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [spsfl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [spsfl_pkg::CFG_DATA_W-1:0]    cfg_data,
    output spsfl_pkg::cfg_t                     cfg
);

    spsfl_pkg::cfg_t cfg_reg;
    spsfl_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                spsfl_pkg::REG_TARGET_POT:    cfg_next.target_pot    = cfg_data;
                spsfl_pkg::REG_STOP_TOL:      cfg_next.stop_tol      = cfg_data;
                spsfl_pkg::REG_REENGAGE_TOL:  cfg_next.reengage_tol  = cfg_data;
                spsfl_pkg::REG_EDGE_GUARD:    cfg_next.edge_guard    = cfg_data[6:0];
                spsfl_pkg::REG_FAULT_LOW:     cfg_next.fault_low     = cfg_data;
                spsfl_pkg::REG_FAULT_HIGH:    cfg_next.fault_high    = cfg_data;
                spsfl_pkg::REG_FAULT_RUN_LEN: cfg_next.fault_run_len = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_pot    <= spsfl_pkg::RST_TARGET_POT;
            cfg_reg.stop_tol      <= spsfl_pkg::RST_STOP_TOL;
            cfg_reg.reengage_tol  <= spsfl_pkg::RST_REENGAGE_TOL;
            cfg_reg.edge_guard    <= spsfl_pkg::RST_EDGE_GUARD;
            cfg_reg.fault_low     <= spsfl_pkg::RST_FAULT_LOW;
            cfg_reg.fault_high    <= spsfl_pkg::RST_FAULT_HIGH;
            cfg_reg.fault_run_len <= spsfl_pkg::RST_FAULT_RUN_LEN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/spsfl_core.sv =====
`timescale 1ns / 1ps
// servo state and single-pass turn and drive decision
module spsfl_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  spsfl_pkg::item_t     item,
    input  spsfl_pkg::cfg_t      cfg,
    output spsfl_pkg::result_t   result,
    output spsfl_pkg::status_t   status
);

    logic [7:0] run_reg;
    logic [7:0] run_next;
    logic       aligned_reg;
    logic       aligned_next;
    logic       frozen_reg;
    logic       frozen_next;
    logic [7:0] reading_reg;
    logic [7:0] reading_next;

    logic [7:0] cur;
    logic       is_extreme;
    logic [7:0] run_inc;
    logic       err_pos;
    logic       err_neg;
    logic [7:0] mag;
    logic       hold;
    logic [7:0] high_edge;
    logic       edge_block;
    spsfl_pkg::turn_cmd_t cmd;

    assign cur        = item.pot_raw[9:2];
    assign is_extreme = (cur == cfg.fault_low) || (cur == cfg.fault_high);
    assign run_inc    = (run_reg < cfg.fault_run_len) ? run_reg + 8'd1 : run_reg;
    assign err_pos    = cfg.target_pot > cur;
    assign err_neg    = cfg.target_pot < cur;
    assign mag        = err_neg ? cur - cfg.target_pot : cfg.target_pot - cur;
    // hysteresis: an aligned pod uses the wider re-engage window
    assign hold       = aligned_reg ? (mag <= cfg.reengage_tol) : (mag <= cfg.stop_tol);
    assign high_edge  = spsfl_pkg::POT_MAX - {1'b0, cfg.edge_guard};
    assign edge_block = ((cur <= {1'b0, cfg.edge_guard}) && err_neg)
                     || ((cur >= high_edge) && err_pos);

    always_comb
    begin
        run_next     = run_reg;
        aligned_next = aligned_reg;
        frozen_next  = frozen_reg;
        reading_next = reading_reg;
        cmd          = spsfl_pkg::TURN_STOP;
        if (item.op == spsfl_pkg::OP_TURN)
        begin
            if (frozen_reg)
            begin
                aligned_next = 1'b0;
            end
            else
            begin
                reading_next = cur;
                if (is_extreme)
                begin
                    run_next = run_inc;
                    // freeze takes effect from the next word on
                    if (run_inc >= cfg.fault_run_len)
                    begin
                        frozen_next = 1'b1;
                    end
                end
                else
                begin
                    run_next = 8'd0;
                end
                aligned_next = hold;
                if (!hold && !edge_block)
                begin
                    cmd = err_pos ? spsfl_pkg::TURN_INC : spsfl_pkg::TURN_DEC;
                end
            end
        end
    end

    always_comb
    begin
        result.turn_valid   = (item.op == spsfl_pkg::OP_TURN);
        result.turn_cmd     = cmd;
        result.drive_valid  = (item.op == spsfl_pkg::OP_DRIVE);
        result.drive_stop   = (item.op == spsfl_pkg::OP_DRIVE) && frozen_reg;
        result.drive_effort = ((item.op == spsfl_pkg::OP_DRIVE) && !frozen_reg)
                            ? item.drive_request : 8'sd0;
        result.pot_value    = reading_next;
        result.aligned_flag = aligned_next;
        result.fault_flag   = frozen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 8'd0;
            aligned_reg <= 1'b0;
            frozen_reg  <= 1'b0;
            reading_reg <= spsfl_pkg::RST_LAST_READING;
        end
        else if (fire)
        begin
            run_reg     <= run_next;
            aligned_reg <= aligned_next;
            frozen_reg  <= frozen_next;
            reading_reg <= reading_next;
        end
    end

    assign status.frozen  = frozen_reg;
    assign status.aligned = aligned_reg;

endmodule

// ===== rtl/steering_pot_servo_with_fault_latch.sv =====
`timescale 1ns / 1ps
// top level of the bang-bang steering servo with pot fault latch
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser op, tdata pot_raw, drive_request
// m_*      out  m_tvalid/m_tready  tuser turn_valid, drive_valid; tdata result fields
// cfg_*    in   cfg_we             cfg_index, cfg_data (no read-back)
//
// one word accepted per cycle while the output is not stalled, one result word per input word
// each word passes the input register, then the decision into the result register
// the decision is a single pass of compares and a run counter update
// reset clears the servo state and loads the register defaults
// a stalled output holds its word; the input register keeps filling until both are full
module steering_pot_servo_with_fault_latch
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [spsfl_pkg::S_TDATA_W-1:0]       s_tdata,  // pot_raw[9:0], drive_request[17:10]
    input  logic                                  s_tuser,  // op
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [spsfl_pkg::M_TDATA_W-1:0]       m_tdata,  // turn_cmd[1:0], drive_stop[2],
                                                            // drive_effort[10:3], pot_value[18:11],
                                                            // aligned_flag[19], fault_flag[20]
    output logic [spsfl_pkg::M_TUSER_W-1:0]       m_tuser,  // turn_valid[0], drive_valid[1]
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [spsfl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [spsfl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    spsfl_pkg::cfg_t    cfg;
    spsfl_pkg::result_t result;
    spsfl_pkg::status_t status;

    // input register
    logic               in_valid_reg;
    logic               in_valid_next;
    spsfl_pkg::item_t   in_item_reg;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    spsfl_pkg::result_t out_res_reg;

    logic               advance;
    logic               fire;
    logic               take;

    // result stage free or being drained this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg.op            <= spsfl_pkg::op_t'(s_tuser);
            in_item_reg.pot_raw       <= s_tdata[9:0];
            in_item_reg.drive_request <= s_tdata[17:10];
        end
        if (fire)
        begin
            out_res_reg <= result;
        end
    end

    spsfl_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spsfl_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result),
        .status (status)
    );

    // result word packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_res_reg.drive_valid, out_res_reg.turn_valid};
    assign m_tdata  = {3'd0,
                       out_res_reg.fault_flag,
                       out_res_reg.aligned_flag,
                       out_res_reg.pot_value,
                       out_res_reg.drive_effort,
                       out_res_reg.drive_stop,
                       out_res_reg.turn_cmd};

    // fault freeze never releases
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(status.frozen) |-> status.frozen)
        else $error("fault freeze released");

    // a drive word under fault is forced to stop with zero effort
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.drive_valid && out_res_reg.fault_flag)
        |-> (out_res_reg.drive_stop && (out_res_reg.drive_effort == 8'sd0)))
        else $error("drive not stopped under fault");

    // each result word is either a turn word or a drive word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot({out_res_reg.drive_valid, out_res_reg.turn_valid}))
        else $error("result word kind not unique");

    // an aligned pod never commands a turn
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.aligned_flag)
        |-> (out_res_reg.turn_cmd == spsfl_pkg::TURN_STOP))
        else $error("turn commanded while aligned");

endmodule
